// File: rtl/sism_pkg.sv
// Shared types and codes for the sorted interval set with insert-merge.
package sism_pkg;

	// Operation carried by one input item.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_POINT  = 2'd1,
		ACT_ISECT  = 2'd2,
		ACT_FRAC   = 2'd3
	} action_t;

	// Status reported with every result.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_ORDER = 2'd2
	} status_t;

	// Control sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PROD,
		S_QUERY,
		S_MERGE,
		S_DONE
	} state_t;

	// Broadcast control from the sequencer to every storage cell.
	typedef struct packed {
		action_t action;
		logic    shift;
		logic    write;
	} cell_ctrl_t;

	// Fixed width of the Q0.16 threshold and of the coordinate ports.
	localparam int THR_BITS  = 16;
	localparam int PORT_BITS = 16;
	localparam int CNT_PORT_BITS = 5;

endpackage

// File: rtl/sism_cell.sv
// One storage cell of the interval chain: holds one interval and tests it against a query.
module sism_cell #(
	parameter int CW    = 16,
	parameter int PW    = 32,
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  sism_pkg::cell_ctrl_t ctrl,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [CW-1:0]       w_low,
	input  logic [CW-1:0]       w_high,
	input  logic [CW-1:0]       nxt_low,
	input  logic [CW-1:0]       nxt_high,
	input  logic [CW-1:0]       q_lo,
	input  logic [CW-1:0]       q_hi,
	input  logic [CW-1:0]       q_pt,
	input  logic [PW-1:0]       prod,
	input  logic                valid,
	output logic [CW-1:0]       low,
	output logic [CW-1:0]       high,
	output logic                hit,
	output logic                meet
);
	import sism_pkg::*;

	logic [CW-1:0] low_q;
	logic [CW-1:0] high_q;
	logic [CW-1:0] ov_lo;
	logic [CW-1:0] ov_hi;
	logic [CW-1:0] ov_len;
	logic          frac_pass;
	logic          sel;

	assign sel = ctrl.write && (wr_idx == IDX_W'(INDEX));

	// A write of a merge result takes priority over the shift from the neighbor.
	always_ff @(posedge clk) begin
		if (sel) begin
			low_q  <= w_low;
			high_q <= w_high;
		end else if (ctrl.shift) begin
			low_q  <= nxt_low;
			high_q <= nxt_high;
		end
	end

	assign low  = low_q;
	assign high = high_q;

	// The stored interval shares at least one point with the query interval.
	assign meet = valid && !(high_q < q_lo || q_hi < low_q);

	// Overlap length against the query, compared with the scaled threshold.
	always_comb begin
		ov_lo     = (low_q > q_lo) ? low_q : q_lo;
		ov_hi     = (high_q < q_hi) ? high_q : q_hi;
		ov_len    = ov_hi - ov_lo;
		frac_pass = (ov_hi > ov_lo) && ({ov_len, {THR_BITS{1'b0}}} > prod);
	end

	// Per-cell answer for the active query kind.
	always_comb begin
		case (ctrl.action)
			ACT_POINT: hit = valid && (low_q <= q_pt) && (q_pt <= high_q);
			ACT_ISECT: hit = meet;
			ACT_FRAC:  hit = valid && frac_pass;
			default:   hit = 1'b0;
		endcase
	end

endmodule

// File: rtl/sorted_interval_set_merge.sv
// Top level of the sorted interval set: cell chain and the control sequencer.
//
// Usage: one input channel (in_valid/in_ready) carries action, lo, hi, point and
// threshold; one output channel (out_valid/out_ready) returns hit, status and
// count, exactly one result for every input transfer. The block works on one
// item at a time: in_ready is high only while it is idle, and the result is
// held on the output until its transfer completes, after which a new input
// can be taken in the next cycle.
// States from input transfer to out_valid:
//   point and intersect queries: check, query, result,
//   overlap-fraction queries: check, product (registered), query, result,
//   inverted bounds or an insert into a full table meeting no stored interval:
//   check, result; any other insert: check, a merge pass that rotates the
//   whole cell chain through its head cell once, one cell per cycle, result.
// The block takes a new item only after the result of the last one has been
// transferred.
// A stalled receiver simply holds the block in its result state.
// Reset clears the interval count and the sequencer; the cell contents are
// left as they are and only entries below the count are ever used.
module sorted_interval_set_merge #(
	parameter int CAPACITY   = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [sism_pkg::PORT_BITS-1:0] lo,
	input  logic [sism_pkg::PORT_BITS-1:0] hi,
	input  logic [sism_pkg::PORT_BITS-1:0] point,
	input  logic [sism_pkg::THR_BITS-1:0]  threshold,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [1:0]                     status,
	output logic [4:0]                     count
);
	import sism_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int PW    = COORD_BITS + THR_BITS;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t               state_q;
	state_t               state_d;
	action_t              act_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW-1:0]        pt_q;
	logic [THR_BITS-1:0]  thr_q;
	logic [PW-1:0]        prod_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     step_q;
	logic [CNT_W-1:0]     emit_cnt_q;
	logic [CW-1:0]        p_low_q;
	logic [CW-1:0]        p_high_q;
	logic                 p_v_q;
	logic [CW-1:0]        c_low_q;
	logic [CW-1:0]        c_high_q;
	logic                 c_v_q;
	logic                 res_hit_q;
	status_t              res_status_q;

	logic [31:0]          lo_ext;
	logic [31:0]          hi_ext;
	logic [31:0]          pt_ext;
	logic [31:0]          cnt_ext;

	cell_ctrl_t           ctrl;
	logic [IDX_W-1:0]     wr_idx;
	logic [CW-1:0]        cl_low  [CAPACITY];
	logic [CW-1:0]        cl_high [CAPACITY];
	logic [CAPACITY-1:0]  cl_hit;
	logic [CAPACITY-1:0]  cl_meet;
	logic [CAPACITY-1:0]  cl_valid;
	logic                 any_hit;
	logic                 any_meet;
	logic                 order_err;
	logic                 table_full;

	// Merge step signals.
	logic                 step_last;
	logic                 head_v;
	logic                 head_meet;
	logic                 emit;
	logic [CW-1:0]        e_low;
	logic [CW-1:0]        e_high;
	logic [CW-1:0]        p_low_d;
	logic [CW-1:0]        p_high_d;
	logic                 p_v_d;
	logic [CW-1:0]        c_low_d;
	logic [CW-1:0]        c_high_d;
	logic                 c_v_d;
	logic [CNT_W:0]       tail_idx;

	// Coordinates are zero-extended or cut to COORD_BITS bits before use.
	assign lo_ext = 32'(lo);
	assign hi_ext = 32'(hi);
	assign pt_ext = 32'(point);

	// Input capture.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action_t'(action);
			lo_q  <= lo_ext[CW-1:0];
			hi_q  <= hi_ext[CW-1:0];
			pt_q  <= pt_ext[CW-1:0];
			thr_q <= threshold;
		end
	end

	// Threshold scaled by the query length, one multiplier.
	always_ff @(posedge clk) begin
		if (state_q == S_PROD) begin
			prod_q <= PW'(thr_q) * PW'(hi_q - lo_q);
		end
	end

	// Cell chain: cell k takes the contents of cell k+1 on every shift in which it is not written.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [CW-1:0] nl;
		logic [CW-1:0] nh;

		if (g == CAPACITY - 1) begin : g_tail
			assign nl = cl_low[g];
			assign nh = cl_high[g];
		end else begin : g_body
			assign nl = cl_low[g+1];
			assign nh = cl_high[g+1];
		end

		assign cl_valid[g] = (32'(count_q) > g);

		sism_cell #(
			.CW    (CW),
			.PW    (PW),
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_idx   (wr_idx),
			.w_low    (e_low),
			.w_high   (e_high),
			.nxt_low  (nl),
			.nxt_high (nh),
			.q_lo     (lo_q),
			.q_hi     (hi_q),
			.q_pt     (pt_q),
			.prod     (prod_q),
			.valid    (cl_valid[g]),
			.low      (cl_low[g]),
			.high     (cl_high[g]),
			.hit      (cl_hit[g]),
			.meet     (cl_meet[g])
		);
	end

	assign any_hit    = |cl_hit;
	assign any_meet   = |cl_meet;
	assign order_err  = (act_q != ACT_POINT) && (lo_q > hi_q);
	assign table_full = (count_q == CNT_W'(CAPACITY)) && !any_meet;

	// One step of the streaming merge: the head cell against the pending
	// interval, with a one-entry carry once the new interval has gone out.
	always_comb begin
		step_last = (step_q == CNT_W'(CAPACITY));
		head_v    = (step_q < count_q);
		head_meet = !(cl_high[0] < p_low_q || p_high_q < cl_low[0]);
		emit      = 1'b0;
		e_low     = cl_low[0];
		e_high    = cl_high[0];
		p_low_d   = p_low_q;
		p_high_d  = p_high_q;
		p_v_d     = p_v_q;
		c_low_d   = c_low_q;
		c_high_d  = c_high_q;
		c_v_d     = c_v_q;
		if (step_last) begin
			if (c_v_q) begin
				emit   = 1'b1;
				e_low  = c_low_q;
				e_high = c_high_q;
			end else if (p_v_q) begin
				emit   = 1'b1;
				e_low  = p_low_q;
				e_high = p_high_q;
			end
		end else if (c_v_q) begin
			emit     = 1'b1;
			e_low    = c_low_q;
			e_high   = c_high_q;
			c_low_d  = cl_low[0];
			c_high_d = cl_high[0];
			c_v_d    = head_v;
		end else if (p_v_q) begin
			if (!head_v) begin
				emit   = 1'b1;
				e_low  = p_low_q;
				e_high = p_high_q;
				p_v_d  = 1'b0;
			end else if (cl_high[0] < p_low_q) begin
				emit = 1'b1;
			end else if (head_meet) begin
				p_low_d  = (cl_low[0] < p_low_q) ? cl_low[0] : p_low_q;
				p_high_d = (cl_high[0] > p_high_q) ? cl_high[0] : p_high_q;
			end else begin
				emit     = 1'b1;
				e_low    = p_low_q;
				e_high   = p_high_q;
				p_v_d    = 1'b0;
				c_low_d  = cl_low[0];
				c_high_d = cl_high[0];
				c_v_d    = 1'b1;
			end
		end else begin
			emit = head_v;
		end
	end

	// The written entry lands just after the outputs already packed behind
	// the shifting originals.
	assign tail_idx = (CNT_W+1)'(CAPACITY - 1) - {1'b0, step_q} + {1'b0, emit_cnt_q};
	assign wr_idx   = step_last ? emit_cnt_q[IDX_W-1:0] : tail_idx[IDX_W-1:0];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (order_err) begin
					state_d = S_DONE;
				end else if (act_q == ACT_INSERT) begin
					state_d = table_full ? S_DONE : S_MERGE;
				end else if (act_q == ACT_FRAC) begin
					state_d = S_PROD;
				end else begin
					state_d = S_QUERY;
				end
			end
			S_PROD:  state_d = S_QUERY;
			S_QUERY: state_d = S_DONE;
			S_MERGE: begin
				if (step_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready    = (state_q == S_IDLE);
		out_valid   = (state_q == S_DONE);
		ctrl.action = act_q;
		ctrl.shift  = (state_q == S_MERGE) && !step_last;
		ctrl.write  = (state_q == S_MERGE) && emit;
	end

	// Sequencer and merge control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			emit_cnt_q   <= '0;
			p_v_q        <= 1'b0;
			c_v_q        <= 1'b0;
			res_hit_q    <= 1'b0;
			res_status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CHECK: begin
					res_hit_q    <= 1'b0;
					res_status_q <= order_err ? STAT_ORDER :
						((act_q == ACT_INSERT && table_full) ? STAT_FULL : STAT_OK);
					step_q       <= '0;
					emit_cnt_q   <= '0;
					p_v_q        <= 1'b1;
					c_v_q        <= 1'b0;
				end
				S_QUERY: begin
					res_hit_q <= any_hit;
				end
				S_MERGE: begin
					step_q     <= step_q + 1'b1;
					emit_cnt_q <= emit_cnt_q + CNT_W'(emit);
					p_v_q      <= p_v_d;
					c_v_q      <= c_v_d;
					if (step_last) begin
						count_q <= emit_cnt_q + CNT_W'(emit);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Merge payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			p_low_q  <= lo_q;
			p_high_q <= hi_q;
		end else if (state_q == S_MERGE) begin
			p_low_q  <= p_low_d;
			p_high_q <= p_high_d;
			c_low_q  <= c_low_d;
			c_high_q <= c_high_d;
		end
	end

	assign cnt_ext = 32'(count_q);
	assign hit     = res_hit_q;
	assign status  = res_status_q;
	assign count   = cnt_ext[CNT_PORT_BITS-1:0];

	// The stored count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("interval count above capacity");

	// The count only changes at the end of a merge pass.
	a_count_merge: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == S_MERGE))
		else $error("interval count changed outside a merge");

	// A dropped insert is reported only with a full table.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_status_q == STAT_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with free entries");

	// Every input transfer leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("input transfer not followed by check");

endmodule
